### sv/clh_pkg.sv
// ----------------------------------------------------------------------------
// clh_pkg: shared types and constants of the call latency histogram
// Request and result layouts, start table entry, sequencer states and codes.
// ----------------------------------------------------------------------------
package clh_pkg;

	typedef struct packed {
		logic        command;
		logic [31:0] thread_id;
		logic [31:0] process_id;
		logic [63:0] timestamp_ns;
		logic [2:0]  operation;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  op_out;
		logic [5:0]  slot;
		logic [31:0] bin_count;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] thread;
		logic [63:0] start;
	} entry_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SLOT,
		S_HIST_RD,
		S_HIST_WR
	} state_t;

	localparam logic [2:0] STAT_STARTED   = 3'd0;
	localparam logic [2:0] STAT_FILTERED  = 3'd1;
	localparam logic [2:0] STAT_FULL      = 3'd2;
	localparam logic [2:0] STAT_RECORDED  = 3'd3;
	localparam logic [2:0] STAT_NO_START  = 3'd4;
	localparam logic [2:0] STAT_BAD_OP    = 3'd5;
	localparam logic [2:0] STAT_NEG_DELTA = 3'd6;

	localparam logic CMD_ENTRY  = 1'b0;
	localparam logic CMD_RETURN = 1'b1;

	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_UNIT   = 1'b1;

	localparam logic [63:0] US_DIV = 64'd1000;
	localparam logic [63:0] MS_DIV = 64'd1000000;

endpackage

### sv/call_latency_log2_histogram_core.sv
// ----------------------------------------------------------------------------
// call_latency_log2_histogram_core: per-thread call latency log2 histogram
// Entry requests store a start time per thread; return requests bin the
// scaled latency into a saturating per-operation log2 histogram.
// After reset the tables are cleared with busy high; configuration writes
// are taken meanwhile. A filtered entry gives its result in the cycle after
// acceptance. Any other request scans the start table one entry per cycle
// through its read port; a recorded return then steps through the slot
// compares (S_SLOT), a histogram read (S_HIST_RD) and write (S_HIST_WR).
// One request is in flight at a time; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module call_latency_log2_histogram_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int NUM_OPS     = 5,
	parameter int NUM_SLOTS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  clh_pkg::req_t request,
	output logic          done,
	output clh_pkg::res_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int HIST_DEPTH = NUM_OPS * NUM_SLOTS;
	localparam int HIST_W     = $clog2(HIST_DEPTH);
	localparam int CLR_LEN    = (TABLE_DEPTH > HIST_DEPTH) ? TABLE_DEPTH : HIST_DEPTH;
	localparam int CLR_W      = $clog2(CLR_LEN);

	clh_pkg::state_t state_q, state_d;
	clh_pkg::req_t   req_q;
	clh_pkg::res_t   result_q, res_d;
	clh_pkg::entry_t entry_mem [TABLE_DEPTH];
	clh_pkg::entry_t ent_rd_q, ent_wdata;
	logic [31:0]     hist_mem [HIST_DEPTH];
	logic [31:0]     hist_rd_q, hist_wdata, hist_new;

	logic              done_q, done_d;
	logic [31:0]       target_q;
	logic              unit_ms_q;
	logic [CLR_W-1:0]  clr_cnt_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [63:0]       delta_q, thr_q, delta_w;
	logic [5:0]        slot_q;

	logic              accept, filtered, hit, scan_end, op_bad, slot_end, rd_issue;
	logic              ent_we, hist_we, cfg_wr;
	logic [IDX_W-1:0]  ent_waddr;
	logic [HIST_W-1:0] hist_addr, hist_waddr;

	assign busy     = (state_q != clh_pkg::S_IDLE);
	assign accept   = start && !busy;
	assign filtered = (request.command == clh_pkg::CMD_ENTRY) && (target_q != 32'd0) &&
		(target_q != request.process_id);
	assign hit      = rd_pend_s1 && ent_rd_q.valid && (ent_rd_q.thread == req_q.thread_id);
	assign scan_end = !rd_pend_s1 && (rd_cnt_q == CNT_W'(TABLE_DEPTH));
	assign rd_issue = (state_q == clh_pkg::S_SCAN) && (32'(rd_cnt_q) < TABLE_DEPTH);
	assign delta_w  = req_q.timestamp_ns - ent_rd_q.start;
	assign op_bad   = (32'(req_q.operation) >= NUM_OPS);
	assign slot_end = (slot_q == 6'(NUM_SLOTS - 1)) || (thr_q > delta_q);
	assign hist_addr = HIST_W'(32'(req_q.operation) * NUM_SLOTS + 32'(slot_q));
	assign hist_new  = (hist_rd_q == 32'hFFFF_FFFF) ? hist_rd_q : hist_rd_q + 32'd1;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == clh_pkg::REG_UNIT) ? {31'd0, unit_ms_q} : target_q;
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			clh_pkg::S_CLEAR: begin
				if (clr_cnt_q == CLR_W'(CLR_LEN - 1)) state_d = clh_pkg::S_IDLE;
			end
			clh_pkg::S_IDLE: begin
				if (accept && !filtered) state_d = clh_pkg::S_SCAN;
			end
			clh_pkg::S_SCAN: begin
				if (hit) begin
					if (req_q.command == clh_pkg::CMD_ENTRY || op_bad || delta_w[63])
						state_d = clh_pkg::S_IDLE;
					else
						state_d = clh_pkg::S_SLOT;
				end else if (scan_end) begin
					state_d = clh_pkg::S_IDLE;
				end
			end
			clh_pkg::S_SLOT: begin
				if (slot_end) state_d = clh_pkg::S_HIST_RD;
			end
			clh_pkg::S_HIST_RD: state_d = clh_pkg::S_HIST_WR;
			clh_pkg::S_HIST_WR: state_d = clh_pkg::S_IDLE;
			default: state_d = clh_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ent_we           = 1'b0;
		ent_waddr        = idx_s1;
		ent_wdata.valid  = 1'b0;
		ent_wdata.thread = req_q.thread_id;
		ent_wdata.start  = req_q.timestamp_ns;
		hist_we          = 1'b0;
		hist_waddr       = hist_addr;
		hist_wdata       = hist_new;
		done_d           = 1'b0;
		res_d            = '0;
		case (state_q)
			clh_pkg::S_CLEAR: begin
				ent_we     = (32'(clr_cnt_q) < TABLE_DEPTH);
				ent_waddr  = IDX_W'(clr_cnt_q);
				hist_we    = (32'(clr_cnt_q) < HIST_DEPTH);
				hist_waddr = HIST_W'(clr_cnt_q);
				hist_wdata = 32'd0;
			end
			clh_pkg::S_IDLE: begin
				if (accept && filtered) begin
					done_d       = 1'b1;
					res_d.status = clh_pkg::STAT_FILTERED;
				end
			end
			clh_pkg::S_SCAN: begin
				if (hit) begin
					ent_we = 1'b1;
					if (req_q.command == clh_pkg::CMD_ENTRY) begin
						ent_wdata.valid = 1'b1;
						done_d          = 1'b1;
						res_d.status    = clh_pkg::STAT_STARTED;
					end else if (op_bad) begin
						done_d       = 1'b1;
						res_d.status = clh_pkg::STAT_BAD_OP;
					end else if (delta_w[63]) begin
						done_d       = 1'b1;
						res_d.status = clh_pkg::STAT_NEG_DELTA;
					end
				end else if (scan_end) begin
					done_d = 1'b1;
					if (req_q.command == clh_pkg::CMD_RETURN) begin
						res_d.status = clh_pkg::STAT_NO_START;
					end else if (free_found_q) begin
						ent_we          = 1'b1;
						ent_waddr       = free_idx_q;
						ent_wdata.valid = 1'b1;
						res_d.status    = clh_pkg::STAT_STARTED;
					end else begin
						res_d.status = clh_pkg::STAT_FULL;
					end
				end
			end
			clh_pkg::S_HIST_WR: begin
				hist_we         = 1'b1;
				done_d          = 1'b1;
				res_d.status    = clh_pkg::STAT_RECORDED;
				res_d.op_out    = req_q.operation;
				res_d.slot      = slot_q;
				res_d.bin_count = hist_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= clh_pkg::S_CLEAR;
			done_q       <= 1'b0;
			clr_cnt_q    <= '0;
			target_q     <= 32'd0;
			unit_ms_q    <= 1'b0;
			rd_cnt_q     <= '0;
			rd_pend_s1   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			rd_pend_s1 <= rd_issue && (state_d == clh_pkg::S_SCAN);
			if (state_q == clh_pkg::S_CLEAR) clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			if (cfg_wr) begin
				case (paddr[2])
					clh_pkg::REG_TARGET: target_q  <= pwdata;
					clh_pkg::REG_UNIT:   unit_ms_q <= pwdata[0];
					default: ;
				endcase
			end
			if (accept) begin
				rd_cnt_q     <= '0;
				free_found_q <= 1'b0;
			end else begin
				if (rd_issue) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				if (rd_pend_s1 && !ent_rd_q.valid && !free_found_q) free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= request;
		if (done_d) result_q <= res_d;
		if (rd_issue) idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (rd_pend_s1 && !ent_rd_q.valid && !free_found_q) free_idx_q <= idx_s1;
		if (state_q == clh_pkg::S_SCAN && hit) begin
			delta_q <= delta_w;
			slot_q  <= 6'd0;
			thr_q   <= (unit_ms_q ? clh_pkg::MS_DIV : clh_pkg::US_DIV) << 1;
		end else if (state_q == clh_pkg::S_SLOT && !slot_end) begin
			slot_q <= slot_q + 6'd1;
			thr_q  <= thr_q << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) entry_mem[ent_waddr] <= ent_wdata;
		if (rd_issue) ent_rd_q <= entry_mem[rd_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		if (state_q == clh_pkg::S_HIST_RD) hist_rd_q <= hist_mem[hist_addr];
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still in progress");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted request neither in progress nor answered");

	a_recorded_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == clh_pkg::STAT_RECORDED) |->
		(32'(result.slot) < NUM_SLOTS && 32'(result.op_out) < NUM_OPS &&
		result.bin_count != 32'd0))
		else $error("recorded sample out of range");

	a_other_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != clh_pkg::STAT_RECORDED) |->
		(result.op_out == 3'd0 && result.slot == 6'd0 && result.bin_count == 32'd0))
		else $error("unrecorded result carries sample fields");

endmodule
